/* rtl/lgs_pkg.sv */
// ----------------------------------------------------------------------------
// lgs_pkg
// Shared types and constants for the bounded Life grid block.
// ----------------------------------------------------------------------------
package lgs_pkg;

  // Default grid bounds for the top level
  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;

  // Size registers
  localparam int SIZE_W = 7;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE = 1'b1;

  // Command codes
  localparam logic [1:0] CMD_WRITE_CELL = 2'd0;
  localparam logic [1:0] CMD_READ_CELL  = 2'd1;
  localparam logic [1:0] CMD_ADVANCE    = 2'd2;

  // Status codes
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  // Life rule neighbor counts
  localparam logic [3:0] SURVIVE_LOW  = 4'd2;
  localparam logic [3:0] SURVIVE_HIGH = 4'd3;
  localparam logic [3:0] BIRTH_COUNT  = 4'd3;

  typedef struct packed {
    logic [1:0] command;
    logic [5:0] cell_row;
    logic [5:0] cell_col;
    logic       cell_value;
  } lgs_in_t;

  typedef struct packed {
    logic read_value;
    logic status;
  } lgs_out_t;

endpackage

/* rtl/lgs_rule.sv */
// ----------------------------------------------------------------------------
// lgs_rule
// Life rule over one grid row: counts the eight neighbors of every column
// from the row itself and the rows above and below and builds the next row.
// ----------------------------------------------------------------------------
module lgs_rule import lgs_pkg::*; #(
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic [MAX_COLS-1:0] above_i,
  input  logic [MAX_COLS-1:0] row_i,
  input  logic [MAX_COLS-1:0] below_i,
  input  logic [MAX_COLS-1:0] col_mask_i,
  input  logic                row_live_i,
  output logic [MAX_COLS-1:0] next_o
);

  // Left neighbor of column c sits in bit c of the up-shifted row
  logic [MAX_COLS-1:0] above_l, above_r, row_l, row_r, below_l, below_r;

  assign above_l = above_i << 1;
  assign above_r = above_i >> 1;
  assign row_l   = row_i << 1;
  assign row_r   = row_i >> 1;
  assign below_l = below_i << 1;
  assign below_r = below_i >> 1;

  always_comb begin
    logic [3:0] cnt;
    next_o = '0;
    for (int c = 0; c < MAX_COLS; c++) begin
      cnt = 4'(above_l[c]) + 4'(above_i[c]) + 4'(above_r[c])
          + 4'(row_l[c]) + 4'(row_r[c])
          + 4'(below_l[c]) + 4'(below_i[c]) + 4'(below_r[c]);
      next_o[c] = row_live_i && col_mask_i[c] &&
                  ((row_i[c] && (cnt == SURVIVE_LOW || cnt == SURVIVE_HIGH)) ||
                   (!row_i[c] && cnt == BIRTH_COUNT));
    end
  end

endmodule

/* rtl/life_grid_generation_step_top.sv */
// ----------------------------------------------------------------------------
// life_grid_generation_step_top
// Bounded Life grid: cell write, cell read and one-generation advance,
// with the grid held one row per word in a synchronous memory.
// ----------------------------------------------------------------------------
//  channel | signals                                   | transfer when
//  --------+-------------------------------------------+-------------------------
//  in      | in_valid_i, in_ready_o, in_data_i         | in_valid_i & in_ready_o
//  out     | out_valid_o, out_ready_i, out_data_o      | out_valid_o & out_ready_i
//  cfg     | cfg_we_i, cfg_idx_i, cfg_data_i           | cfg_we_i
//
// Cell write or read: row read, modify or pick, result; out of range goes straight to the result.
// Advance: one memory row read and one row written back per cycle through a
// three-row window, limited by the single row-wide memory.
// After reset a clearing pass writes every row dead, with in_ready_o low.
// One command at a time; a new command is taken while the last result still waits
// in the output register, and a finished result holds until that register frees.
module life_grid_generation_step_top import lgs_pkg::*; #(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  lgs_in_t              in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output lgs_out_t             out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [SIZE_W-1:0]    cfg_data_i
);

  localparam int RAW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CAW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int KW  = $clog2(MAX_ROWS + 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CELL,
    ST_GEN,
    ST_RESP
  } state_e;

  // Size registers
  logic [SIZE_W-1:0] rows_q, cols_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= SIZE_RESET;
      cols_q <= SIZE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ROWS_IN_USE: rows_q <= cfg_data_i;
        CFG_COLS_IN_USE: cols_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Grid memory, one row per word
  logic [MAX_COLS-1:0] grid_mem [MAX_ROWS];
  logic                mem_we, mem_re;
  logic [RAW-1:0]      mem_wa, mem_ra;
  logic [MAX_COLS-1:0] mem_wd, rd_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      grid_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= grid_mem[mem_ra];
    end
  end

  // Control state
  state_e              state_q, state_d;
  logic [KW-1:0]       k_q, k_d;
  logic [MAX_COLS-1:0] prev_q, prev_d, cur_q, cur_d;
  logic                is_wr_q, is_wr_d;
  logic [RAW-1:0]      row_q, row_d;
  logic [CAW-1:0]      col_q, col_d;
  logic                val_q, val_d;
  lgs_out_t            res_q, res_d;
  logic                out_valid_q, out_valid_d;
  lgs_out_t            out_data_q, out_data_d;

  logic [MAX_COLS-1:0] col_mask, nxt_row, new_row;
  logic                in_xfer, in_range, nxt_live, out_live;

  always_comb begin
    for (int c = 0; c < MAX_COLS; c++) begin
      col_mask[c] = c < int'(cols_q);
    end
  end

  assign in_xfer  = in_valid_i && in_ready_o;
  assign in_range = (int'(in_data_i.cell_row) < int'(rows_q)) &&
                    (int'(in_data_i.cell_row) < MAX_ROWS) &&
                    (int'(in_data_i.cell_col) < int'(cols_q)) &&
                    (int'(in_data_i.cell_col) < MAX_COLS);

  // Row k enters the window; row k-1 is rebuilt
  assign nxt_live = (int'(k_q) < MAX_ROWS) && (int'(k_q) < int'(rows_q));
  assign out_live = int'(k_q) <= int'(rows_q);
  assign nxt_row  = nxt_live ? (rd_q & col_mask) : '0;

  lgs_rule #(
    .MAX_COLS(MAX_COLS)
  ) u_rule (
    .above_i   (prev_q),
    .row_i     (cur_q),
    .below_i   (nxt_row),
    .col_mask_i(col_mask),
    .row_live_i(out_live),
    .next_o    (new_row)
  );

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    prev_d      = prev_q;
    cur_d       = cur_q;
    is_wr_d     = is_wr_q;
    row_d       = row_q;
    col_d       = col_q;
    val_d       = val_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_wa      = '0;
    mem_ra      = '0;
    mem_wd      = '0;

    case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = RAW'(k_q);
        if (k_q == KW'(MAX_ROWS - 1)) begin
          k_d     = '0;
          state_d = ST_IDLE;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          res_d   = '{read_value: 1'b0, status: STATUS_OK};
          is_wr_d = in_data_i.command == CMD_WRITE_CELL;
          row_d   = RAW'(in_data_i.cell_row);
          col_d   = CAW'(in_data_i.cell_col);
          val_d   = in_data_i.cell_value;
          state_d = ST_RESP;
          case (in_data_i.command)
            CMD_WRITE_CELL, CMD_READ_CELL: begin
              if (in_range) begin
                mem_re  = 1'b1;
                mem_ra  = RAW'(in_data_i.cell_row);
                state_d = ST_CELL;
              end else begin
                res_d.status = STATUS_RANGE;
              end
            end
            CMD_ADVANCE: begin
              mem_re  = 1'b1;
              mem_ra  = '0;
              k_d     = '0;
              prev_d  = '0;
              cur_d   = '0;
              state_d = ST_GEN;
            end
            default: ;
          endcase
        end
      end
      ST_CELL: begin
        if (is_wr_q) begin
          mem_we        = 1'b1;
          mem_wa        = row_q;
          mem_wd        = rd_q;
          mem_wd[col_q] = val_q;
        end else begin
          res_d.read_value = rd_q[col_q];
        end
        state_d = ST_RESP;
      end
      ST_GEN: begin
        if (k_q != '0) begin
          mem_we = 1'b1;
          mem_wa = RAW'(k_q - 1'b1);
          mem_wd = new_row;
        end
        if (int'(k_q) + 1 < MAX_ROWS) begin
          mem_re = 1'b1;
          mem_ra = RAW'(k_q + 1'b1);
        end
        prev_d = cur_q;
        cur_d  = nxt_row;
        if (k_q == KW'(MAX_ROWS)) begin
          state_d = ST_RESP;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      ST_RESP: begin
        // hold the result until the output register frees
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      prev_q      <= '0;
      cur_q       <= '0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
      prev_q      <= prev_d;
      cur_q       <= cur_d;
    end
  end

  always_ff @(posedge clk_i) begin
    is_wr_q    <= is_wr_d;
    row_q      <= row_d;
    col_q      <= col_d;
    val_q      <= val_d;
    res_q      <= res_d;
    out_data_q <= out_data_d;
  end

  assign in_ready_o  = state_q == ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Generation write-back never lands on the row being fetched
  a_no_same_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && mem_re) |-> (mem_wa != mem_ra))
    else $error("grid row read and written in the same cycle");

  // Out-of-range cell access reports its status on the next cycle
  a_range_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && !in_range && (in_data_i.command == CMD_WRITE_CELL ||
                              in_data_i.command == CMD_READ_CELL))
    |=> (state_q == ST_RESP && res_q.status == STATUS_RANGE))
    else $error("out-of-range access not flagged");

  // A flagged result never carries cell data
  a_range_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == STATUS_RANGE) |-> !out_data_o.read_value)
    else $error("read value on out-of-range result");

  // Generation walk stays within the grid plus the trailing row
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_GEN) |-> (int'(k_q) <= MAX_ROWS))
    else $error("generation row counter overran");

endmodule

/* tb/life_grid_generation_step_top_tb.sv */
// ----------------------------------------------------------------------------
// life_grid_generation_step_top_tb
// Self-checking bench for the bounded Life grid. A directed table covers the
// size extremes, out-of-range accesses, the unused command and edge-clipped
// patterns. Randomized phases follow, each with its own grid size and handshake
// idling: they seed a pattern, advance it and read cells back. Each result is
// checked against a table value or a cycle-free model of grid and Life rule.
// ----------------------------------------------------------------------------
module life_grid_generation_step_top_tb;
  import lgs_pkg::*;

  localparam int GRID_ROWS     = DEF_MAX_ROWS;
  localparam int GRID_COLS     = DEF_MAX_COLS;
  localparam int RANDOM_ITEMS  = 1800;
  localparam int RANDOM_PHASES = 8;
  localparam int SETTLE_CYCLES = GRID_ROWS + 8;
  localparam int RUN_LIMIT     = 2_000_000;

  // Unused command code: no change, plain ok result
  localparam logic [1:0] CMD_SPARE = 2'd3;

  localparam lgs_out_t RES_OK    = '{read_value: 1'b0, status: STATUS_OK};
  localparam lgs_out_t RES_RANGE = '{read_value: 1'b0, status: STATUS_RANGE};

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  typedef struct {
    bit                resize;
    logic [SIZE_W-1:0] rows;
    logic [SIZE_W-1:0] cols;
    lgs_in_t           cmd;
    bit                typed;
    lgs_out_t          want;
  } plan_row_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  lgs_in_t              in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  lgs_out_t             out_data_o;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = CFG_ROWS_IN_USE;
  logic [SIZE_W-1:0]    cfg_data_i  = '0;

  // Grid model and its size registers
  logic [GRID_COLS-1:0] life_cells [GRID_ROWS];
  logic [SIZE_W-1:0]    rows_set = SIZE_RESET;
  logic [SIZE_W-1:0]    cols_set = SIZE_RESET;

  lgs_out_t  due_results [$];
  lgs_out_t  due_head;
  plan_row_t directed_plan [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int fail_count     = 0;
  int results_checked;
  int items_sent;
  int generations_sent;
  int range_hits;
  int size_changes;

  life_grid_generation_step_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #(RUN_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (due_results.size() == 0) begin
        $error("result with no command pending: read_value=%0b status=%0b",
               out_data_o.read_value, out_data_o.status);
        fail_count++;
      end else begin
        due_head = due_results.pop_front();
        if (out_data_o.read_value !== due_head.read_value) begin
          $error("read_value: expected %0b, got %0b", due_head.read_value,
                 out_data_o.read_value);
          fail_count++;
        end
        if (out_data_o.status !== due_head.status) begin
          $error("status: expected %0b, got %0b", due_head.status, out_data_o.status);
          fail_count++;
        end
        results_checked++;
      end
    end
  end

  function automatic int span_of(logic [SIZE_W-1:0] v, int limit);
    return (v > limit) ? limit : int'(v);
  endfunction

  // Build every cell afresh from the old grid, masked to the size in use
  function automatic void next_generation();
    logic [GRID_COLS-1:0] prev [GRID_ROWS];
    int nr, nc, cnt, r, c, dr, dc;
    nr = span_of(rows_set, GRID_ROWS);
    nc = span_of(cols_set, GRID_COLS);
    for (r = 0; r < GRID_ROWS; r++) begin
      for (c = 0; c < GRID_COLS; c++) begin
        prev[r][c] = (r < nr && c < nc) ? life_cells[r][c] : 1'b0;
      end
    end
    for (r = 0; r < GRID_ROWS; r++) begin
      for (c = 0; c < GRID_COLS; c++) begin
        cnt = 0;
        for (dr = -1; dr <= 1; dr++) begin
          for (dc = -1; dc <= 1; dc++) begin
            if ((dr != 0 || dc != 0) && r + dr >= 0 && r + dr < GRID_ROWS &&
                c + dc >= 0 && c + dc < GRID_COLS) begin
              cnt += prev[r + dr][c + dc];
            end
          end
        end
        if (r < nr && c < nc) begin
          life_cells[r][c] = prev[r][c] ? (cnt == SURVIVE_LOW || cnt == SURVIVE_HIGH)
                                        : (cnt == BIRTH_COUNT);
        end else begin
          life_cells[r][c] = 1'b0;
        end
      end
    end
  endfunction

  function automatic lgs_out_t grid_command_result(lgs_in_t it);
    lgs_out_t res;
    int nr, nc;
    res = RES_OK;
    nr = span_of(rows_set, GRID_ROWS);
    nc = span_of(cols_set, GRID_COLS);
    case (it.command)
      CMD_WRITE_CELL, CMD_READ_CELL: begin
        if (it.cell_row >= nr || it.cell_col >= nc) begin
          res.status = STATUS_RANGE;
        end else if (it.command == CMD_WRITE_CELL) begin
          life_cells[it.cell_row][it.cell_col] = it.cell_value;
        end else begin
          res.read_value = life_cells[it.cell_row][it.cell_col];
        end
      end
      CMD_ADVANCE: next_generation();
      default: ;
    endcase
    return res;
  endfunction

  function automatic plan_row_t cmd_row(logic [1:0] cmd, int r, int c, bit v,
                                        bit typed = 1'b0, lgs_out_t want = RES_OK);
    plan_row_t p;
    p.resize = 1'b0;
    p.rows   = '0;
    p.cols   = '0;
    p.cmd    = '{command: cmd, cell_row: r[5:0], cell_col: c[5:0], cell_value: v};
    p.typed  = typed;
    p.want   = want;
    return p;
  endfunction

  function automatic plan_row_t size_row(int r, int c);
    plan_row_t p;
    p = cmd_row(CMD_WRITE_CELL, 0, 0, 1'b0);
    p.resize = 1'b1;
    p.rows   = r[SIZE_W-1:0];
    p.cols   = c[SIZE_W-1:0];
    return p;
  endfunction

  // Append one row to the directed table
  function automatic void add_step(plan_row_t p);
    directed_plan = {directed_plan, p};
  endfunction

  function automatic lgs_in_t make_cmd(logic [1:0] cmd, bit in_range, bit v);
    lgs_in_t it;
    int nr, nc;
    nr = span_of(rows_set, GRID_ROWS);
    nc = span_of(cols_set, GRID_COLS);
    it.command    = cmd;
    it.cell_value = v;
    if (in_range && nr > 0 && nc > 0) begin
      it.cell_row = 6'($urandom_range(nr - 1));
      it.cell_col = 6'($urandom_range(nc - 1));
    end else begin
      it.cell_row = 6'($urandom_range(63));
      it.cell_col = 6'($urandom_range(63));
    end
    return it;
  endfunction

  function automatic logic [SIZE_W-1:0] pick_span();
    case ($urandom_range(9))
      0:       return '0;
      1:       return 7'd1;
      2:       return 7'd64;
      3:       return SIZE_W'($urandom_range(127, 65));
      default: return SIZE_W'($urandom_range(16, 2));
    endcase
  endfunction

  task automatic set_idling(idle_mode_e mode);
    send_idle_pct  = (mode == IDLE_SEND) ? 48 : (mode == IDLE_BOTH) ? 24 : 0;
    recv_stall_pct = (mode == IDLE_RECV) ? 48 : (mode == IDLE_BOTH) ? 24 : 0;
  endtask

  // Transfer one command; valid stays up afterwards unless the next call idles
  task automatic send_cmd(lgs_in_t it, bit typed = 1'b0, lgs_out_t want = RES_OK);
    lgs_out_t got;
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    got = grid_command_result(it);
    due_results = {due_results, (typed ? want : got)};
    items_sent++;
    if (it.command == CMD_ADVANCE) generations_sent++;
    if (got.status == STATUS_RANGE) range_hits++;
  endtask

  // Drop valid and wait until every pending result has come back
  task automatic settle();
    in_valid_i <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_size(logic [SIZE_W-1:0] r, logic [SIZE_W-1:0] c);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_ROWS_IN_USE;
    cfg_data_i <= r;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_COLS_IN_USE;
    cfg_data_i <= c;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    rows_set = r;
    cols_set = c;
    size_changes++;
    @(posedge clk_i);
  endtask

  // Seed a pattern in range, then let it evolve and sample it
  task automatic run_pattern();
    int n;
    n = $urandom_range(24, 4);
    repeat (n) send_cmd(make_cmd(CMD_WRITE_CELL, 1'b1, $urandom_range(99) < 45));
    n = $urandom_range(4, 1);
    repeat (n) begin
      send_cmd(make_cmd(CMD_ADVANCE, 1'b0, 1'($urandom_range(1))));
      repeat ($urandom_range(4, 1)) send_cmd(make_cmd(CMD_READ_CELL, 1'b1, 1'b0));
    end
  endtask

  initial begin
    int p, phase_end;
    for (p = 0; p < GRID_ROWS; p++) life_cells[p] = '0;

    // Reset corner reads, an L that gives a birth, a lonely cell, command 3
    add_step(cmd_row(CMD_READ_CELL, 0, 0, 1'b0, 1'b1, RES_OK));
    add_step(cmd_row(CMD_READ_CELL, 63, 63, 1'b0, 1'b1, RES_OK));
    add_step(cmd_row(CMD_WRITE_CELL, 63, 63, 1'b1));
    add_step(cmd_row(CMD_WRITE_CELL, 0, 0, 1'b1));
    add_step(cmd_row(CMD_WRITE_CELL, 0, 1, 1'b1));
    add_step(cmd_row(CMD_WRITE_CELL, 1, 0, 1'b1));
    add_step(cmd_row(CMD_ADVANCE, 0, 0, 1'b0));
    add_step(cmd_row(CMD_READ_CELL, 1, 1, 1'b0));
    add_step(cmd_row(CMD_READ_CELL, 63, 63, 1'b0));
    add_step(cmd_row(CMD_SPARE, 63, 63, 1'b1, 1'b1, RES_OK));
    // No rows in use: every access out of range, generation clears all
    add_step(size_row(0, 64));
    add_step(cmd_row(CMD_READ_CELL, 0, 0, 1'b0, 1'b1, RES_RANGE));
    add_step(cmd_row(CMD_WRITE_CELL, 0, 0, 1'b1, 1'b1, RES_RANGE));
    add_step(cmd_row(CMD_ADVANCE, 63, 63, 1'b1));
    // Sizes above the maximum clamp; blinker clipped at the bottom edge
    add_step(size_row(127, 127));
    add_step(cmd_row(CMD_READ_CELL, 1, 1, 1'b0));
    add_step(cmd_row(CMD_WRITE_CELL, 63, 0, 1'b1));
    add_step(cmd_row(CMD_WRITE_CELL, 63, 1, 1'b1));
    add_step(cmd_row(CMD_WRITE_CELL, 63, 2, 1'b1));
    add_step(cmd_row(CMD_ADVANCE, 0, 0, 1'b0));
    add_step(cmd_row(CMD_READ_CELL, 62, 1, 1'b0));
    // Single cell grid
    add_step(size_row(1, 1));
    add_step(cmd_row(CMD_WRITE_CELL, 0, 63, 1'b1, 1'b1, RES_RANGE));
    add_step(cmd_row(CMD_READ_CELL, 63, 0, 1'b0, 1'b1, RES_RANGE));
    add_step(cmd_row(CMD_WRITE_CELL, 0, 0, 1'b0, 1'b1, RES_OK));
    // Shrinking and regrowing keeps the cell
    add_step(size_row(5, 64));
    add_step(cmd_row(CMD_WRITE_CELL, 4, 63, 1'b1));
    add_step(size_row(4, 64));
    add_step(cmd_row(CMD_READ_CELL, 4, 63, 1'b0, 1'b1, RES_RANGE));
    add_step(size_row(5, 64));
    add_step(cmd_row(CMD_READ_CELL, 4, 63, 1'b0));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Hold off until the clearing pass lets commands in
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);

    set_idling(IDLE_BOTH);
    foreach (directed_plan[i]) begin
      if (directed_plan[i].resize) begin
        settle();
        set_size(directed_plan[i].rows, directed_plan[i].cols);
      end else begin
        send_cmd(directed_plan[i].cmd, directed_plan[i].typed, directed_plan[i].want);
      end
    end

    for (p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      set_size(pick_span(), pick_span());
      set_idling(idle_mode_e'(p % 4));
      phase_end = items_sent + RANDOM_ITEMS / RANDOM_PHASES;
      while (items_sent < phase_end) begin
        if ($urandom_range(99) < 75) begin
          run_pattern();
        end else begin
          send_cmd(make_cmd(2'($urandom_range(3)), 1'($urandom_range(1)),
                            1'($urandom_range(1))));
        end
      end
    end

    settle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Sent %0d commands: %0d generations, %0d out-of-range accesses, %0d sizes",
             items_sent, generations_sent, range_hits, size_changes);
    $display("Compared %0d results against the grid model", results_checked);
    if (fail_count == 0 && due_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
